@@ rtl/lcd_decimal_digit_writer_macros.svh @@
// Assertion macros for the LCD decimal digit writer.
// Included by the top level; expects clk and rst_n in scope.
`ifndef LCD_DECIMAL_DIGIT_WRITER_MACROS_SVH
`define LCD_DECIMAL_DIGIT_WRITER_MACROS_SVH

`ifndef SYNTHESIS
`define LCDDW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcddw assertion failed");
`define LCDDW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcddw assertion failed");
`else
`define LCDDW_ASSERT_NOW(label, ante, cons)
`define LCDDW_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/lcddw_pkg.sv @@
// Shared types, constants and functions of the LCD decimal digit writer.
// No dependencies.
package lcddw_pkg;

    localparam int NUM_DIGITS = 6;
    localparam int NUM_ROWS   = 4;
    localparam int OUT_W      = 24;
    localparam int ROW_W      = (4 * NUM_DIGITS > OUT_W) ? 4 * NUM_DIGITS : OUT_W;

    localparam logic       OP_CHAR    = 1'b0;
    localparam logic       OP_NUMBER  = 1'b1;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_POS  = 2'd1,
        ST_BAD_CHAR = 2'd2
    } status_t;

    typedef logic [NUM_ROWS-1:0][ROW_W-1:0] rows_t;

    typedef struct packed {
        logic                      op;
        status_t                   status;
        logic [3:0]                digit;
        logic [2:0]                pos;
        logic [NUM_DIGITS:0][3:0]  qlow;
    } item_t;

    // floor(val / 10**k) by reciprocal multiply, exact for 20-bit val
    function automatic logic [19:0] div_pow10(input logic [19:0] val, input int k);
        logic [63:0] prod;
        logic [19:0] q;
        prod = 64'd0;
        q    = 20'd0;
        case (k)
            0:
            begin
                q = val;
            end
            1:
            begin
                prod = 64'(val) * 64'd1677722;
                q    = prod[43:24];
            end
            2:
            begin
                prod = 64'(val) * 64'd1342178;
                q    = prod[46:27];
            end
            3:
            begin
                prod = 64'(val) * 64'd1073742;
                q    = prod[49:30];
            end
            4:
            begin
                prod = 64'(val) * 64'd1717987;
                q    = prod[53:34];
            end
            5:
            begin
                prod = 64'(val) * 64'd1374390;
                q    = prod[56:37];
            end
            6:
            begin
                prod = 64'(val) * 64'd1099512;
                q    = prod[59:40];
            end
            default:
            begin
                q = 20'd0;
            end
        endcase
        return q;
    endfunction

    // four row nibbles of a digit, row 0 in the low nibble
    function automatic logic [15:0] digit_rows(input logic [3:0] d);
        logic [15:0] r;
        case (d)
            4'd0:    r = 16'h1551;
            4'd1:    r = 16'h0110;
            4'd2:    r = 16'h1E11;
            4'd3:    r = 16'h1B11;
            4'd4:    r = 16'h0B50;
            4'd5:    r = 16'h1B41;
            4'd6:    r = 16'h1F41;
            4'd7:    r = 16'h0111;
            4'd8:    r = 16'h1F51;
            4'd9:    r = 16'h1B51;
            default: r = 16'h0000;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/lcddw_decode.sv @@
// Decode of one input item: status check and decimal quotients.
// Depends on lcddw_pkg.
module lcddw_decode
    import lcddw_pkg::*;
(
    input  logic        op,
    input  logic [7:0]  char_code,
    input  logic [2:0]  position,
    input  logic [19:0] number_value,
    output item_t       item
);

    logic [7:0]  char_off;
    logic [19:0] quot [NUM_DIGITS+1];

    assign char_off = char_code - CHAR_ZERO;

    always_comb
    begin
        item.op     = op;
        item.digit  = char_off[3:0];
        item.pos    = position;
        item.status = ST_OK;
        if (op == OP_CHAR)
        begin
            if (char_code < CHAR_ZERO || char_code > CHAR_NINE)
            begin
                item.status = ST_BAD_CHAR;
            end
            else if ({1'b0, position} >= 4'(NUM_DIGITS))
            begin
                item.status = ST_BAD_POS;
            end
        end
        for (int k = 0; k <= NUM_DIGITS; k++)
        begin
            quot[k]      = div_pow10(number_value, k);
            item.qlow[k] = quot[k][3:0];
        end
    end

endmodule

@@ rtl/lcddw_merge.sv @@
// Segment row update: digit extraction, row lookup and nibble merge.
// Depends on lcddw_pkg.
module lcddw_merge
    import lcddw_pkg::*;
(
    input  item_t item,
    input  rows_t rows,
    output rows_t updated
);

    logic [3:0]  dig  [NUM_DIGITS];
    logic [15:0] pat  [NUM_DIGITS];
    logic [15:0] cpat;

    assign cpat = digit_rows(item.digit);

    always_comb
    begin
        updated = rows;
        // digit n = q[n] - 10*q[n+1], low nibble only
        for (int n = 0; n < NUM_DIGITS; n++)
        begin
            dig[n] = item.qlow[n] - {item.qlow[n+1][0], 3'b000}
                                  - {item.qlow[n+1][2:0], 1'b0};
            pat[n] = digit_rows(dig[n]);
        end
        if (item.op == OP_NUMBER)
        begin
            for (int p = 0; p < NUM_DIGITS; p++)
            begin
                for (int r = 0; r < NUM_ROWS; r++)
                begin
                    updated[r][4*p +: 4] = pat[NUM_DIGITS-1-p][4*r +: 4];
                end
            end
        end
        else if (item.status == ST_OK)
        begin
            for (int p = 0; p < NUM_DIGITS; p++)
            begin
                if (item.pos == 3'(p))
                begin
                    for (int r = 0; r < NUM_ROWS; r++)
                    begin
                        updated[r][4*p +: 4] = cpat[4*r +: 4];
                    end
                end
            end
        end
    end

endmodule

@@ rtl/lcd_decimal_digit_writer.sv @@
// Top level of the LCD decimal digit writer: input register and result register.
// Depends on lcddw_pkg, lcddw_decode, lcddw_merge and the assertion macros.
//
//  channel | signals                                         | transfer
//  --------+-------------------------------------------------+---------------------
//  in      | in_valid, in_stall, op, char_code, position,    | in_valid & !in_stall
//          | number_value                                    |
//  out     | out_valid, out_stall, status, row0..row3_bytes  | out_valid & !out_stall
//
// One item per cycle while out is not stalled; each item goes to the input register, then the result register.
// Decode (six reciprocal multipliers) and the row merge sit between the
// input register and the result register.
// Reset clears all segment rows and empties both registers.
// A stall on out holds the result register; in_stall rises only when both
// registers hold items and out is stalled.
`include "lcd_decimal_digit_writer_macros.svh"

module lcd_decimal_digit_writer
    import lcddw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [7:0]  char_code,
    input  logic [2:0]  position,
    input  logic [19:0] number_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [23:0] row0_bytes,
    output logic [23:0] row1_bytes,
    output logic [23:0] row2_bytes,
    output logic [23:0] row3_bytes
);

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic        s1_op_reg;
    logic [7:0]  s1_char_reg;
    logic [2:0]  s1_pos_reg;
    logic [19:0] s1_val_reg;
    item_t       s1_item;

    logic        out_valid_reg;
    logic        out_valid_next;
    status_t     status_reg;
    rows_t       rows_reg;
    rows_t       rows_next;

    logic        out_load;
    logic        s1_load;
    logic        result_load;

    assign out_load    = !out_valid_reg || !out_stall;
    assign s1_load     = !s1_valid_reg || out_load;
    assign result_load = out_load && s1_valid_reg;
    assign in_stall    = !s1_load;

    assign s1_valid_next  = s1_load  ? in_valid     : s1_valid_reg;
    assign out_valid_next = out_load ? s1_valid_reg : out_valid_reg;

    lcddw_decode u_decode (
        .op           (s1_op_reg),
        .char_code    (s1_char_reg),
        .position     (s1_pos_reg),
        .number_value (s1_val_reg),
        .item         (s1_item)
    );

    lcddw_merge u_merge (
        .item    (s1_item),
        .rows    (rows_reg),
        .updated (rows_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rows_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (result_load)
            begin
                rows_reg <= rows_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && in_valid)
        begin
            s1_op_reg   <= op;
            s1_char_reg <= char_code;
            s1_pos_reg  <= position;
            s1_val_reg  <= number_value;
        end
        if (result_load)
        begin
            status_reg <= s1_item.status;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign row0_bytes = rows_reg[0][OUT_W-1:0];
    assign row1_bytes = rows_reg[1][OUT_W-1:0];
    assign row2_bytes = rows_reg[2][OUT_W-1:0];
    assign row3_bytes = rows_reg[3][OUT_W-1:0];

    `LCDDW_ASSERT_NEXT(a_rows_hold, !result_load, $stable(rows_reg))
    `LCDDW_ASSERT_NEXT(a_error_keeps_rows, result_load && (s1_item.status != ST_OK), $stable(rows_reg))
    `LCDDW_ASSERT_NOW(a_stall_only_when_full, in_stall, s1_valid_reg && out_valid_reg && out_stall)

endmodule
